[src/pbvi_pkg.sv]
package pbvi_pkg;

	// Command codes carried in the input tuser field.
	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_FORCE   = 2'd1;
	localparam logic [1:0] FUNC_REFLECT = 2'd2;
	localparam logic [1:0] FUNC_SETVEL  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_MASS      = 3'd0;
	localparam logic [2:0] CFG_REST      = 3'd1;
	localparam logic [2:0] CFG_GRAV_ON   = 3'd2;
	localparam logic [2:0] CFG_GRAV_STEP = 3'd3;
	localparam logic [2:0] CFG_LIMIT_X   = 3'd4;
	localparam logic [2:0] CFG_LIMIT_Y   = 3'd5;

	// Quotient bits produced for each kind of division.
	localparam logic [5:0] FORCE_DIV_STEPS = 6'd32;
	localparam logic [5:0] REFL_DIV_STEPS  = 6'd26;

	// Request into the shared radix-2 divider.
	typedef struct packed {
		logic        start;
		logic [48:0] rem0;
		logic [31:0] bits;
		logic [5:0]  count;
		logic [48:0] divisor;
	} div_req_t;

	// Status and result of the shared divider.
	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quo;
	} div_rsp_t;

endpackage

[src/point_body_velocity_integrator.sv]
// Point body integrator: holds a 2D position (signed Q24.8) and velocity
// (signed Q16.8) and applies one command per request: tick, add force,
// reflect about an unnormalized normal, or set velocity. Every request yields
// one result with the position and velocity after it. The block takes one
// request at a time through a sequencer around a single shared multiplier and
// a single radix-2 divider. An add force runs two 32-bit divisions by the mass,
// a reflect two 26-bit divisions by the squared normal length and ten
// multiplies; a reflect with a zero normal skips the divisions. The input is
// ready again in the cycle after the result is placed in the output register,
// which holds it until it is taken. Configuration writes are always accepted.
module point_body_velocity_integrator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,  // arg_x[23:0], arg_y[47:24], dt[64:48], zero pad
	input  logic [1:0]   s_tuser,  // func[1:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,  // pos_x[31:0], pos_y[63:32], vel_x[87:64], vel_y[111:88]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	import pbvi_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_T_MX  = 5'd1;
	localparam logic [4:0] S_T_MY  = 5'd2;
	localparam logic [4:0] S_T_PY  = 5'd3;
	localparam logic [4:0] S_F_STX = 5'd4;
	localparam logic [4:0] S_F_WX  = 5'd5;
	localparam logic [4:0] S_F_STY = 5'd6;
	localparam logic [4:0] S_F_WY  = 5'd7;
	localparam logic [4:0] S_R_NN0 = 5'd8;
	localparam logic [4:0] S_R_NN1 = 5'd9;
	localparam logic [4:0] S_R_VN0 = 5'd10;
	localparam logic [4:0] S_R_VN1 = 5'd11;
	localparam logic [4:0] S_R_CHK = 5'd12;
	localparam logic [4:0] S_R_P0  = 5'd13;
	localparam logic [4:0] S_R_P1  = 5'd14;
	localparam logic [4:0] S_R_DST = 5'd15;
	localparam logic [4:0] S_R_DW  = 5'd16;
	localparam logic [4:0] S_R_SCX = 5'd17;
	localparam logic [4:0] S_R_SCY = 5'd18;
	localparam logic [4:0] S_R_SCE = 5'd19;
	localparam logic [4:0] S_OUT   = 5'd20;

	localparam logic signed [33:0] V_MAX = 34'sd8388607;
	localparam logic signed [33:0] V_MIN = -34'sd8388608;
	localparam logic signed [33:0] P_MAX = 34'sd2147483647;
	localparam logic signed [33:0] P_MIN = -34'sd2147483648;

	function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
		if (v > V_MAX) return 24'sh7FFFFF;
		else if (v < V_MIN) return 24'sh800000;
		else return $signed(v[23:0]);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > P_MAX) return 32'sh7FFFFFFF;
		else if (v < P_MIN) return 32'sh80000000;
		else return $signed(v[31:0]);
	endfunction

	function automatic logic signed [33:0] qneg_force(input logic signed [23:0] a,
			input logic [31:0] q);
		if (a[23]) return -$signed({2'b00, q});
		else return $signed({2'b00, q});
	endfunction

	// Configuration registers.
	logic [23:0]        mass_q;
	logic [15:0]        rest_q;
	logic               grav_on_q;
	logic signed [15:0] grav_q;
	logic [22:0]        lim_x_q;
	logic [22:0]        lim_y_q;

	// Body state.
	logic signed [23:0] vx_q, vy_q;
	logic signed [31:0] px_q, py_q;

	// Sequencer and working registers.
	logic [4:0]         state_q;
	logic               axis_q;
	logic signed [23:0] ax_q, ay_q;
	logic [16:0]        dt_q;
	logic signed [26:0] rvx_q, rvy_q;
	logic [48:0]        nn_q;
	logic signed [48:0] vn_q;
	logic [47:0]        lo_q;
	logic signed [52:0] prod_q;
	logic               m_tvalid_q;
	logic [111:0]       m_data_q;

	logic signed [27:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [52:0] prod;
	logic signed [23:0] a_sel;
	logic [23:0]        amag;
	logic               qneg;
	logic [47:0]        vnm;
	logic signed [48:0] vn_abs;
	logic [71:0]        dvd;
	logic [23:0]        mass_eff;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic signed [52:0] tick_adj;
	logic signed [52:0] sc_adj;
	logic signed [23:0] sc_val;
	logic signed [33:0] f_acc;
	logic signed [33:0] f_sum;
	logic signed [23:0] f_sat;
	logic signed [23:0] f_lim;
	logic signed [23:0] f_clamp;
	logic signed [26:0] r_q;
	logic signed [26:0] r_new;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_data_q;

	// Operand magnitudes and signs for the current axis.
	assign a_sel    = axis_q ? ay_q : ax_q;
	assign amag     = a_sel[23] ? 24'(-a_sel) : a_sel;
	assign vn_abs   = vn_q[48] ? -vn_q : vn_q;
	assign vnm      = vn_abs[47:0];
	assign qneg     = a_sel[23] ^ vn_q[48];
	assign mass_eff = (mass_q == 24'd0) ? 24'd1 : mass_q;

	// Shared multiplier operand selection.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_T_MX: begin
				mul_a = 28'(vx_q);
				mul_b = $signed({8'b0, dt_q});
			end
			S_T_MY: begin
				mul_a = 28'(vy_q);
				mul_b = $signed({8'b0, dt_q});
			end
			S_R_NN0: begin
				mul_a = 28'(ax_q);
				mul_b = 25'(ax_q);
			end
			S_R_NN1: begin
				mul_a = 28'(ay_q);
				mul_b = 25'(ay_q);
			end
			S_R_VN0: begin
				mul_a = 28'(vx_q);
				mul_b = 25'(ax_q);
			end
			S_R_VN1: begin
				mul_a = 28'(vy_q);
				mul_b = 25'(ay_q);
			end
			S_R_P0: begin
				mul_a = $signed({4'b0, amag});
				mul_b = $signed({1'b0, vnm[23:0]});
			end
			S_R_P1: begin
				mul_a = $signed({4'b0, amag});
				mul_b = $signed({1'b0, vnm[47:24]});
			end
			S_R_SCX: begin
				mul_a = 28'(rvx_q);
				mul_b = $signed({9'b0, rest_q});
			end
			S_R_SCY: begin
				mul_a = 28'(rvy_q);
				mul_b = $signed({9'b0, rest_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk) begin
		prod_q <= prod;
	end

	// Rescaling with truncation toward zero.
	assign tick_adj = prod_q + (prod_q[52] ? 53'sd65535 : 53'sd0);
	assign sc_adj   = prod_q + (prod_q[52] ? 53'sd32767 : 53'sd0);
	assign sc_val   = sat24($signed(sc_adj[48:15]));

	// Add force: apply the quotient, saturate, then clamp to the speed limit.
	assign f_acc   = qneg_force(a_sel, div_rsp.quo);
	assign f_sum   = 34'(axis_q ? vy_q : vx_q) + f_acc;
	assign f_sat   = sat24(f_sum);
	assign f_lim   = $signed({1'b0, (axis_q ? lim_y_q : lim_x_q)});
	assign f_clamp = (f_sat > f_lim) ? f_lim : ((f_sat < -f_lim) ? -f_lim : f_sat);

	// Reflect: subtract the signed quotient from the working velocity.
	assign r_q   = $signed({1'b0, div_rsp.quo[25:0]});
	assign r_new = qneg ? ((axis_q ? rvy_q : rvx_q) + r_q) : ((axis_q ? rvy_q : rvx_q) - r_q);

	// Doubled product of normal component and dot product.
	assign dvd = {({prod_q[46:0], 24'b0} + {23'b0, lo_q}), 1'b0};

	// Divider requests.
	always_comb begin
		div_req = '0;
		unique case (state_q)
			S_F_STX, S_F_STY: begin
				div_req.start   = 1'b1;
				div_req.rem0    = '0;
				div_req.bits    = {amag, 8'b0};
				div_req.count   = FORCE_DIV_STEPS;
				div_req.divisor = {25'b0, mass_eff};
			end
			S_R_DST: begin
				div_req.start   = 1'b1;
				div_req.rem0    = {3'b0, dvd[71:26]};
				div_req.bits    = {dvd[25:0], 6'b0};
				div_req.count   = REFL_DIV_STEPS;
				div_req.divisor = nn_q;
			end
			default: div_req = '0;
		endcase
	end

	pbvi_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Request capture and working payload.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ax_q  <= $signed(s_tdata[23:0]);
			ay_q  <= $signed(s_tdata[47:24]);
			dt_q  <= s_tdata[64:48];
			rvx_q <= 27'(vx_q);
			rvy_q <= 27'(vy_q);
		end
		unique case (state_q)
			S_R_NN1: nn_q <= prod_q[48:0];
			S_R_VN0: nn_q <= nn_q + prod_q[48:0];
			S_R_VN1: vn_q <= prod_q[48:0];
			S_R_CHK: vn_q <= vn_q + prod_q[48:0];
			S_R_P1:  lo_q <= prod_q[47:0];
			S_R_DW: begin
				if (div_rsp.done) begin
					if (axis_q) rvy_q <= r_new;
					else rvx_q <= r_new;
				end
			end
			default: begin
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q    <= 24'd256;
			rest_q    <= 16'd32768;
			grav_on_q <= 1'b0;
			grav_q    <= 16'sd2509;
			lim_x_q   <= 23'd1280000;
			lim_y_q   <= 23'd1280000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MASS:      mass_q    <= cfg_data;
				CFG_REST:      rest_q    <= cfg_data[15:0];
				CFG_GRAV_ON:   grav_on_q <= cfg_data[0];
				CFG_GRAV_STEP: grav_q    <= $signed(cfg_data[15:0]);
				CFG_LIMIT_X:   lim_x_q   <= cfg_data[22:0];
				CFG_LIMIT_Y:   lim_y_q   <= cfg_data[22:0];
				default: begin
				end
			endcase
		end
	end

	// Command sequencer, body state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			axis_q     <= 1'b0;
			vx_q       <= '0;
			vy_q       <= '0;
			px_q       <= '0;
			py_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// The output valid is set when a result is loaded and cleared when it is taken.
			if (state_q == S_OUT && (!m_tvalid_q || m_tready)) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						axis_q <= 1'b0;
						unique case (s_tuser)
							FUNC_TICK: begin
								if (grav_on_q) vy_q <= sat24(34'(vy_q) + 34'(grav_q));
								state_q <= S_T_MX;
							end
							FUNC_FORCE:   state_q <= S_F_STX;
							FUNC_REFLECT: state_q <= S_R_NN0;
							default: begin
								vx_q    <= $signed(s_tdata[23:0]);
								vy_q    <= $signed(s_tdata[47:24]);
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_T_MX: state_q <= S_T_MY;
				S_T_MY: begin
					px_q    <= sat32(34'(px_q) + $signed(tick_adj[49:16]));
					state_q <= S_T_PY;
				end
				S_T_PY: begin
					py_q    <= sat32(34'(py_q) + $signed(tick_adj[49:16]));
					state_q <= S_OUT;
				end
				S_F_STX: state_q <= S_F_WX;
				S_F_WX: begin
					if (div_rsp.done) begin
						vx_q    <= f_clamp;
						axis_q  <= 1'b1;
						state_q <= S_F_STY;
					end
				end
				S_F_STY: state_q <= S_F_WY;
				S_F_WY: begin
					if (div_rsp.done) begin
						vy_q    <= f_clamp;
						state_q <= S_OUT;
					end
				end
				S_R_NN0: state_q <= S_R_NN1;
				S_R_NN1: state_q <= S_R_VN0;
				S_R_VN0: state_q <= S_R_VN1;
				S_R_VN1: state_q <= S_R_CHK;
				S_R_CHK: state_q <= (nn_q == 49'd0) ? S_R_SCX : S_R_P0;
				S_R_P0:  state_q <= S_R_P1;
				S_R_P1:  state_q <= S_R_DST;
				S_R_DST: state_q <= S_R_DW;
				S_R_DW: begin
					if (div_rsp.done) begin
						if (axis_q) begin
							state_q <= S_R_SCX;
						end else begin
							axis_q  <= 1'b1;
							state_q <= S_R_P0;
						end
					end
				end
				S_R_SCX: state_q <= S_R_SCY;
				S_R_SCY: begin
					vx_q    <= sc_val;
					state_q <= S_R_SCE;
				end
				S_R_SCE: begin
					vy_q    <= sc_val;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload, loaded when the result is handed to the output.
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!m_tvalid_q || m_tready)) begin
			m_data_q <= {vy_q, vx_q, py_q, px_q};
		end
	end

endmodule

[src/pbvi_divider.sv]
module pbvi_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  pbvi_pkg::div_req_t req,
	output pbvi_pkg::div_rsp_t rsp
);
	import pbvi_pkg::*;

	logic [48:0] rem_q;
	logic [48:0] div_q;
	logic [31:0] shf_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [49:0] trial;
	logic [50:0] diff;
	logic        take;

	// One restoring step: shift in the next dividend bit and try a subtract.
	assign trial = {rem_q, shf_q[31]};
	assign diff  = {1'b0, trial} - {2'b00, div_q};
	assign take  = !diff[50];

	// Sequencing of the iteration count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.count;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder, dividend and quotient registers.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem0;
			shf_q <= req.bits;
			div_q <= req.divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[48:0] : trial[48:0];
			shf_q <= {shf_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], take};
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, quo: quo_q};

endmodule

[src/pbvi_checker.sv]
module pbvi_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [111:0] m_tdata
);
	logic [1:0] pend_q;
	logic       s_acc;
	logic       m_acc;

	assign s_acc = s_tvalid && s_tready;
	assign m_acc = m_tvalid && m_tready;

	// Requests accepted whose result has not been taken yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + {1'b0, s_acc} - {1'b0, m_acc};
		end
	end

	// A request is worked on alone: the input closes right after acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_tready)
		else $error("input stayed ready after a request");

	// No result without an outstanding request.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pend_q != 2'd0)
		else $error("result shown with no request outstanding");

	// One result in the output register and one in work at most.
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many requests outstanding");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind point_body_velocity_integrator pbvi_checker u_pbvi_checker (.*);
